### sv/ftdd_pkg.sv
// Package for the frame tile dirty detector.
// Holds sizes, register indexes, shared structs and the clamp helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ftdd_pkg;

  // frame and tile limits
  localparam int MAX_WIDTH        = 4096;
  localparam int MAX_HEIGHT       = 4096;
  localparam int MAX_TILE_COLUMNS = 4096;
  localparam int TILE_MAX         = 4096;
  localparam int PIXEL_BITS       = 32;
  localparam int PIXEL_BYTES_MAX  = PIXEL_BITS / 8;

  // field widths
  localparam int POS_W   = 12;
  localparam int SIZE_W  = 13;
  localparam int BC_W    = 3;
  localparam int COL_W   = $clog2(MAX_TILE_COLUMNS);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 3'd4;

  // reset values of the registers
  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 13'd1080;
  localparam logic [SIZE_W-1:0] RST_TILE_WIDTH   = 13'd64;
  localparam logic [SIZE_W-1:0] RST_TILE_HEIGHT  = 13'd64;
  localparam logic [BC_W-1:0]   RST_PIXEL_BYTES  = 3'd4;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [SIZE_W-1:0] tile_width;
    logic [SIZE_W-1:0] tile_height;
    logic [BC_W-1:0]   pixel_bytes;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  dirty_x;
    logic [POS_W-1:0]  dirty_y;
    logic [SIZE_W-1:0] dirty_width;
    logic [SIZE_W-1:0] dirty_height;
    logic              tile_valid;
    logic              frame_end;
    logic              frame_dirty;
  } res_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic             data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } mem_rd_t;

  // zero acts as one, values above hi saturate
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/ftdd_ifs.sv
// Channel interfaces of the frame tile dirty detector: pixel pairs in, results out.
// Depends on ftdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ftdd_pix_if;
  import ftdd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] old_pixel;
  logic [PIXEL_BITS-1:0] new_pixel;

  modport source (output valid, output old_pixel, output new_pixel, input ready);
  modport sink   (input valid, input old_pixel, input new_pixel, output ready);
endinterface

interface ftdd_res_if;
  import ftdd_pkg::*;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  dirty_x;
  logic [POS_W-1:0]  dirty_y;
  logic [SIZE_W-1:0] dirty_width;
  logic [SIZE_W-1:0] dirty_height;
  logic              tile_valid;
  logic              frame_end;
  logic              frame_dirty;

  modport source (output valid, output dirty_x, output dirty_y, output dirty_width,
                  output dirty_height, output tile_valid, output frame_end,
                  output frame_dirty, input ready);
  modport sink   (input valid, input dirty_x, input dirty_y, input dirty_width,
                  input dirty_height, input tile_valid, input frame_end,
                  input frame_dirty, output ready);
endinterface

`default_nettype wire

### sv/ftdd_flag_ram.sv
// Dirty flag store, one bit per tile column, one write and one read port.
// Read data is registered. Depends on ftdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ftdd_flag_ram (
  input  wire logic             clk,
  input  ftdd_pkg::mem_wr_t     wr,
  input  ftdd_pkg::mem_rd_t     rd,
  output logic                  q
);
  import ftdd_pkg::*;

  logic mem [MAX_TILE_COLUMNS];
  logic q_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port, holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd.en) begin
      q_r <= mem[rd.addr];
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

### sv/ftdd_tracker.sv
// Input register, raster and tile counters, pixel compare and tile flag handling.
// Depends on ftdd_pkg and ftdd_pix_if.
`timescale 1ns / 1ps
`default_nettype none

module ftdd_tracker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         clr_busy,
  ftdd_pix_if.sink          in_ch,
  input  ftdd_pkg::cfg_t    cfg,
  input  wire logic         buf_full,
  input  wire logic         mem_q,
  output ftdd_pkg::mem_wr_t wr,
  output ftdd_pkg::mem_rd_t rd,
  output logic              push,
  output ftdd_pkg::res_t    res
);
  import ftdd_pkg::*;

  // input register
  logic                  s1_valid_r, s1_valid_nxt;
  logic [PIXEL_BITS-1:0] s1_old_r, s1_new_r;

  // raster and tile state
  logic [POS_W-1:0] px_col_r, px_col_nxt;
  logic [POS_W-1:0] px_line_r, px_line_nxt;
  logic [POS_W-1:0] offx_r, offx_nxt;
  logic [POS_W-1:0] offy_r, offy_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] orgx_r, orgx_nxt;
  logic [POS_W-1:0] orgy_r, orgy_nxt;
  logic             any_r, any_nxt;
  logic             cur_flag_r, cur_flag_nxt;
  logic             fresh_r, fresh_nxt;

  logic [SIZE_W-1:0] fw, fh, tw, th;
  logic [BC_W-1:0]   nb;
  logic [SIZE_W-1:0] col_p1, line_p1, offx_p1, offy_p1;
  logic line_end, last_line, tile_x_end, tile_y_end, frame_end, both_end;
  logic diff, flag_eff, flag_acc, tile_rep, report, go, accept;
  logic wr_data;

  // clamped configuration
  always_comb begin
    fw = clamp_size(cfg.frame_width, SIZE_W'(MAX_WIDTH));
    fh = clamp_size(cfg.frame_height, SIZE_W'(MAX_HEIGHT));
    tw = clamp_size(cfg.tile_width, SIZE_W'(TILE_MAX));
    th = clamp_size(cfg.tile_height, SIZE_W'(TILE_MAX));
    if (cfg.pixel_bytes == '0) begin
      nb = BC_W'(1);
    end else if (cfg.pixel_bytes > BC_W'(PIXEL_BYTES_MAX)) begin
      nb = BC_W'(PIXEL_BYTES_MAX);
    end else begin
      nb = cfg.pixel_bytes;
    end
  end

  // compare the low bytes only
  always_comb begin
    diff = 1'b0;
    for (int i = 0; i < PIXEL_BYTES_MAX; i++) begin
      if (BC_W'(i) < nb && s1_old_r[8*i +: 8] != s1_new_r[8*i +: 8]) begin
        diff = 1'b1;
      end
    end
  end

  // position decode
  always_comb begin
    col_p1     = {1'b0, px_col_r} + SIZE_W'(1);
    line_p1    = {1'b0, px_line_r} + SIZE_W'(1);
    offx_p1    = {1'b0, offx_r} + SIZE_W'(1);
    offy_p1    = {1'b0, offy_r} + SIZE_W'(1);
    line_end   = col_p1 >= fw;
    last_line  = line_p1 >= fh;
    tile_x_end = line_end || offx_p1 >= tw;
    tile_y_end = last_line || offy_p1 >= th;
    frame_end  = line_end && last_line;
    both_end   = tile_x_end && tile_y_end;
    flag_eff   = fresh_r ? mem_q : cur_flag_r;
    flag_acc   = flag_eff | diff;
    tile_rep   = both_end && flag_acc;
    report     = tile_rep || frame_end;
    wr_data    = both_end ? 1'b0 : flag_acc;
  end

  // handshake of the input register
  assign go           = s1_valid_r && (!report || !buf_full);
  assign in_ch.ready  = !clr_busy && (!s1_valid_r || go);
  assign accept       = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = accept ? 1'b1 : (go ? 1'b0 : s1_valid_r);

  // result item
  always_comb begin
    res = '0;
    if (tile_rep) begin
      res.dirty_x      = orgx_r;
      res.dirty_y      = orgy_r;
      res.dirty_width  = offx_p1;
      res.dirty_height = offy_p1;
      res.tile_valid   = 1'b1;
    end
    if (frame_end) begin
      res.frame_end   = 1'b1;
      res.frame_dirty = any_r | tile_rep;
    end
  end
  assign push = go && report;

  // next state of counters
  always_comb begin
    px_col_nxt  = px_col_r;
    px_line_nxt = px_line_r;
    offx_nxt    = offx_r;
    offy_nxt    = offy_r;
    col_nxt     = col_r;
    orgx_nxt    = orgx_r;
    orgy_nxt    = orgy_r;
    any_nxt     = any_r | tile_rep;
    if (frame_end) begin
      any_nxt     = 1'b0;
      px_col_nxt  = '0;
      px_line_nxt = '0;
      offx_nxt    = '0;
      offy_nxt    = '0;
      col_nxt     = '0;
      orgx_nxt    = '0;
      orgy_nxt    = '0;
    end else if (line_end) begin
      px_col_nxt  = '0;
      offx_nxt    = '0;
      col_nxt     = '0;
      orgx_nxt    = '0;
      px_line_nxt = line_p1[POS_W-1:0];
      if (tile_y_end) begin
        orgy_nxt = orgy_r + offy_p1[POS_W-1:0];
        offy_nxt = '0;
      end else begin
        offy_nxt = offy_p1[POS_W-1:0];
      end
    end else begin
      px_col_nxt = col_p1[POS_W-1:0];
      if (tile_x_end) begin
        orgx_nxt = orgx_r + offx_p1[POS_W-1:0];
        offx_nxt = '0;
        col_nxt  = col_r + COL_W'(1);
      end else begin
        offx_nxt = offx_p1[POS_W-1:0];
      end
    end
  end

  // flag store traffic: save on leaving a tile column, fetch the next one
  always_comb begin
    wr.en   = go && tile_x_end;
    wr.addr = col_r;
    wr.data = wr_data;
    rd.en   = go && tile_x_end && (col_nxt != col_r);
    rd.addr = col_nxt;
    cur_flag_nxt = cur_flag_r;
    fresh_nxt    = fresh_r;
    if (go) begin
      if (!tile_x_end) begin
        cur_flag_nxt = flag_acc;
        fresh_nxt    = 1'b0;
      end else if (col_nxt == col_r) begin
        cur_flag_nxt = wr_data;
        fresh_nxt    = 1'b0;
      end else begin
        fresh_nxt = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      px_col_r   <= '0;
      px_line_r  <= '0;
      offx_r     <= '0;
      offy_r     <= '0;
      col_r      <= '0;
      orgx_r     <= '0;
      orgy_r     <= '0;
      any_r      <= 1'b0;
      cur_flag_r <= 1'b0;
      fresh_r    <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      cur_flag_r <= cur_flag_nxt;
      fresh_r    <= fresh_nxt;
      if (go) begin
        px_col_r  <= px_col_nxt;
        px_line_r <= px_line_nxt;
        offx_r    <= offx_nxt;
        offy_r    <= offy_nxt;
        col_r     <= col_nxt;
        orgx_r    <= orgx_nxt;
        orgy_r    <= orgy_nxt;
        any_r     <= any_nxt;
      end
    end
  end

  // pixel payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_old_r <= in_ch.old_pixel;
      s1_new_r <= in_ch.new_pixel;
    end
  end

endmodule

`default_nettype wire

### sv/ftdd_out_buf.sv
// Two-entry result buffer that decouples the result channel from the pipeline.
// Depends on ftdd_pkg and ftdd_res_if.
`timescale 1ns / 1ps
`default_nettype none

module ftdd_out_buf (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  ftdd_pkg::res_t res,
  output logic           full,
  ftdd_res_if.source     out_ch
);
  import ftdd_pkg::*;

  res_t       ent_r [2];
  logic       head_r, head_nxt;
  logic       tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  res_t       hd;

  assign full         = cnt_r == 2'd2;
  assign out_ch.valid = cnt_r != 2'd0;
  assign pop          = out_ch.valid && out_ch.ready;

  // pointer and count update
  always_comb begin
    head_nxt = pop ? ~head_r : head_r;
    tail_nxt = push ? ~tail_r : tail_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      tail_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[tail_r] <= res;
    end
  end

  // head item onto the channel
  assign hd                  = ent_r[head_r];
  assign out_ch.dirty_x      = hd.dirty_x;
  assign out_ch.dirty_y      = hd.dirty_y;
  assign out_ch.dirty_width  = hd.dirty_width;
  assign out_ch.dirty_height = hd.dirty_height;
  assign out_ch.tile_valid   = hd.tile_valid;
  assign out_ch.frame_end    = hd.frame_end;
  assign out_ch.frame_dirty  = hd.frame_dirty;

endmodule

`default_nettype wire

### sv/frame_tile_dirty_detector.sv
// Frame tile dirty detector, top level: registers, flag clearing, core and buffer.
// A result passes through the input register and the result buffer before it is offered.
// Throughput: one pixel pair per cycle, set by the single read-modify-write of the
// tile column flag store; a full result buffer stalls only items that give a result.
// Reset: synchronous, active low; a clearing pass then sweeps all 4096 entries of the
// flag store one entry a cycle, with input ready low; register writes are taken.
`timescale 1ns / 1ps
`default_nettype none

module frame_tile_dirty_detector (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ftdd_pix_if.sink                            in_ch,
  ftdd_res_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ftdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ftdd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ftdd_pkg::*;

  cfg_t             cfg_r;
  logic             clr_r;
  logic [COL_W-1:0] clr_idx_r;
  mem_wr_t          core_wr, ram_wr;
  mem_rd_t          core_rd;
  logic             mem_q, push, buf_full;
  res_t             res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= RST_FRAME_WIDTH;
      cfg_r.frame_height <= RST_FRAME_HEIGHT;
      cfg_r.tile_width   <= RST_TILE_WIDTH;
      cfg_r.tile_height  <= RST_TILE_HEIGHT;
      cfg_r.pixel_bytes  <= RST_PIXEL_BYTES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data;
        REG_TILE_WIDTH:   cfg_r.tile_width   <= cfg_data;
        REG_TILE_HEIGHT:  cfg_r.tile_height  <= cfg_data;
        REG_PIXEL_BYTES:  cfg_r.pixel_bytes  <= cfg_data[BC_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass over the flag store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + COL_W'(1);
      if (clr_idx_r == COL_W'(MAX_TILE_COLUMNS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clr_r) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clr_idx_r;
      ram_wr.data = 1'b0;
    end else begin
      ram_wr = core_wr;
    end
  end

  ftdd_flag_ram u_flag_ram (
    .clk (clk),
    .wr  (ram_wr),
    .rd  (core_rd),
    .q   (mem_q)
  );

  ftdd_tracker u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_r),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .buf_full (buf_full),
    .mem_q    (mem_q),
    .wr       (core_wr),
    .rd       (core_rd),
    .push     (push),
    .res      (res)
  );

  ftdd_out_buf u_out_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .res    (res),
    .full   (buf_full),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
